[hdl/jds_pkg.sv]
// Shared types and constants for the joystick dead-zone scaler.
// No dependencies; used by every module in hdl/.
package jds_pkg;

    localparam int unsigned QUO_W = 7;   // quotient bits, covers 0..100
    localparam int unsigned NUM_W = 15;  // 8-bit difference times 100
    localparam int unsigned DIV_W = 8;
    localparam int unsigned N_REG = 4;

    localparam logic [2:0] DIR_NEUTRAL = 3'd0;
    localparam logic [2:0] DIR_UP      = 3'd1;
    localparam logic [2:0] DIR_LEFT    = 3'd2;
    localparam logic [2:0] DIR_DOWN    = 3'd3;
    localparam logic [2:0] DIR_RIGHT   = 3'd4;

    localparam logic [1:0] REG_NEUTRAL_X  = 2'd0;
    localparam logic [1:0] REG_NEUTRAL_Y  = 2'd1;
    localparam logic [1:0] REG_DEAD_ZONE  = 2'd2;
    localparam logic [1:0] REG_FULL_SCALE = 2'd3;

    localparam logic [7:0] RST_NEUTRAL    = 8'd128;
    localparam logic [6:0] RST_DEAD_ZONE  = 7'd10;
    localparam logic [7:0] RST_FULL_SCALE = 8'd255;
    localparam logic [7:0] PCT_FULL       = 8'd100;

    typedef struct packed {
        logic [7:0] x_sample;
        logic [7:0] y_sample;
    } t_in_req;

    typedef struct packed {
        logic signed [7:0] x_percent;
        logic signed [7:0] y_percent;
        logic [2:0]        direction;
    } t_out_req;

    typedef struct packed {
        logic [7:0] neutral_x;
        logic [7:0] neutral_y;
        logic [6:0] dead_zone;
        logic [7:0] full_scale;
    } t_cfg;

    // one axis in flight through the divider chain
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] rem;
        logic [DIV_W-1:0] div;
        logic [QUO_W-1:0] quo;
    } t_lane;

    typedef struct packed {
        logic  valid;
        t_lane x;
        t_lane y;
    } t_stage;

endpackage

[hdl/jds_front.sv]
// Front stage: dead-zone compare and numerator/divisor setup per axis.
// Depends on jds_pkg.
module jds_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  jds_pkg::t_in_req i_req,
    input  jds_pkg::t_cfg   i_cfg,
    output jds_pkg::t_stage o_stage
);

    logic            r_valid;
    jds_pkg::t_lane  r_x;
    jds_pkg::t_lane  r_y;
    jds_pkg::t_stage n_stage;

    function automatic jds_pkg::t_lane setup_axis(
        input logic [7:0] s,
        input logic [7:0] n,
        input logic [6:0] dz,
        input logic [7:0] fs
    );
        jds_pkg::t_lane       l;
        logic [8:0]           hi;
        logic [7:0]           lo;
        logic [7:0]           diff;
        logic [7:0]           den;
        logic                 has_lo;
        hi     = {1'b0, n} + {2'b0, dz};
        has_lo = (n >= {1'b0, dz});
        lo     = n - {1'b0, dz};
        l.quo  = '0;
        l.neg  = 1'b0;
        l.rem  = '0;
        l.div  = 8'd1;
        diff   = '0;
        den    = 8'd1;
        if ({1'b0, s} > hi) begin
            if (s >= fs) begin
                l.rem = jds_pkg::NUM_W'(jds_pkg::PCT_FULL);  // saturate: 100 / 1
            end else begin
                diff  = 8'(({1'b0, s} - hi));
                den   = 8'(({1'b0, fs} - hi));
                l.rem = jds_pkg::NUM_W'(diff) * jds_pkg::NUM_W'(jds_pkg::PCT_FULL);
                l.div = den;
            end
        end else if (has_lo && (s < lo)) begin
            diff  = lo - s;
            l.neg = 1'b1;
            l.rem = jds_pkg::NUM_W'(diff) * jds_pkg::NUM_W'(jds_pkg::PCT_FULL);
            l.div = lo;
        end
        return l;
    endfunction

    always_comb begin
        n_stage.valid = i_valid;
        n_stage.x = setup_axis(i_req.x_sample, i_cfg.neutral_x, i_cfg.dead_zone,
                               i_cfg.full_scale);
        n_stage.y = setup_axis(i_req.y_sample, i_cfg.neutral_y, i_cfg.dead_zone,
                               i_cfg.full_scale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= n_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x <= n_stage.x;
            r_y <= n_stage.y;
        end
    end

    assign o_stage = '{valid: r_valid, x: r_x, y: r_y};

endmodule

[hdl/jds_cell.sv]
// Divider cell: resolves one quotient bit for both axes, then registers.
// Depends on jds_pkg.
module jds_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  jds_pkg::t_stage i_stage,
    output jds_pkg::t_stage o_stage
);

    logic            r_valid;
    jds_pkg::t_lane  r_x;
    jds_pkg::t_lane  r_y;
    jds_pkg::t_stage n_stage;

    function automatic jds_pkg::t_lane step(input jds_pkg::t_lane l);
        jds_pkg::t_lane             o;
        logic [jds_pkg::NUM_W-1:0] dsh;
        o   = l;
        dsh = jds_pkg::NUM_W'(l.div) << SHIFT;
        if (l.rem >= dsh) begin
            o.rem        = l.rem - dsh;
            o.quo[SHIFT] = 1'b1;
        end
        return o;
    endfunction

    always_comb begin
        n_stage.valid = i_stage.valid;
        n_stage.x     = step(i_stage.x);
        n_stage.y     = step(i_stage.y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= n_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x <= n_stage.x;
            r_y <= n_stage.y;
        end
    end

    assign o_stage = '{valid: r_valid, x: r_x, y: r_y};

endmodule

[hdl/jds_back.sv]
// Back stage: sign restore, 4-way direction, output register.
// Depends on jds_pkg.
module jds_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  jds_pkg::t_stage  i_stage,
    output logic             o_valid,
    output jds_pkg::t_out_req o_req
);

    logic              r_valid;
    jds_pkg::t_out_req r_req;
    jds_pkg::t_out_req n_req;
    logic signed [8:0] a;
    logic signed [8:0] b;

    always_comb begin
        a = i_stage.x.neg ? -$signed({2'b0, i_stage.x.quo}) : $signed({2'b0, i_stage.x.quo});
        b = i_stage.y.neg ? -$signed({2'b0, i_stage.y.quo}) : $signed({2'b0, i_stage.y.quo});
        n_req.x_percent = a[7:0];
        n_req.y_percent = b[7:0];
        // diagonals: x=y>0 up, -x=y>0 left, x=y<0 left, x=-y>0 down
        priority if (a == 9'sd0 && b == 9'sd0) begin
            n_req.direction = jds_pkg::DIR_NEUTRAL;
        end else if (b > 9'sd0 && b >= a && b > -a) begin
            n_req.direction = jds_pkg::DIR_UP;
        end else if (a < 9'sd0 && b <= -a && b >= a) begin
            n_req.direction = jds_pkg::DIR_LEFT;
        end else if (b < 9'sd0 && a > b && a <= -b) begin
            n_req.direction = jds_pkg::DIR_DOWN;
        end else begin
            n_req.direction = jds_pkg::DIR_RIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

[hdl/joystick_deadzone_scaler_top.sv]
// Top level of the joystick dead-zone scaler: config registers and pipeline.
// Depends on jds_pkg, jds_front, jds_cell, jds_back.
//
// Usage:
//   Input channel (i_valid / o_stall / i_sample) takes one raw X/Y sample pair
//   per request. Output channel (o_valid / i_stall / o_result) gives one
//   result per request: X and Y percent in -100..100 and a 4-way direction.
//   The pipeline has one setup stage, seven divider cells (one quotient
//   bit each, restoring compare/subtract), and the output register.
//   One request per cycle unless stalled; the whole chain moves together.
//   When the receiver stalls with a result waiting, the chain freezes and
//   o_stall rises the same cycle; empty slots still fill while the output
//   register is free, and the output register stays loaded until taken.
//   Reset clears all stage valid bits and loads the config defaults
//   (neutral 128/128, dead zone 10, full scale 255).
//   Config: APB, registers at byte offsets 0x0 neutral_x, 0x4 neutral_y,
//   0x8 dead_zone, 0xC full_scale. pready is tied high; reads return the
//   register value zero-extended. Write config only while the block is idle.
module joystick_deadzone_scaler_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample requests
    input  logic              i_valid,
    output logic              o_stall,
    input  jds_pkg::t_in_req  i_sample,
    // result requests
    output logic              o_valid,
    input  logic              i_stall,
    output jds_pkg::t_out_req o_result,
    // APB config
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    jds_pkg::t_cfg   r_cfg;
    logic            adv;
    logic [1:0]      reg_idx;
    jds_pkg::t_stage chain [jds_pkg::QUO_W+1];

    // ---------------- config registers ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neutral_x  <= jds_pkg::RST_NEUTRAL;
            r_cfg.neutral_y  <= jds_pkg::RST_NEUTRAL;
            r_cfg.dead_zone  <= jds_pkg::RST_DEAD_ZONE;
            r_cfg.full_scale <= jds_pkg::RST_FULL_SCALE;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                jds_pkg::REG_NEUTRAL_X:  r_cfg.neutral_x  <= pwdata[7:0];
                jds_pkg::REG_NEUTRAL_Y:  r_cfg.neutral_y  <= pwdata[7:0];
                jds_pkg::REG_DEAD_ZONE:  r_cfg.dead_zone  <= pwdata[6:0];
                jds_pkg::REG_FULL_SCALE: r_cfg.full_scale <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            jds_pkg::REG_NEUTRAL_X:  prdata = {24'd0, r_cfg.neutral_x};
            jds_pkg::REG_NEUTRAL_Y:  prdata = {24'd0, r_cfg.neutral_y};
            jds_pkg::REG_DEAD_ZONE:  prdata = {25'd0, r_cfg.dead_zone};
            jds_pkg::REG_FULL_SCALE: prdata = {24'd0, r_cfg.full_scale};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    // Whole chain advances unless a finished result is held by the receiver.
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    jds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_req   (i_sample),
        .i_cfg   (r_cfg),
        .o_stage (chain[0])
    );

    // cell k resolves quotient bit QUO_W-1-k, MSB first
    for (genvar k = 0; k < jds_pkg::QUO_W; k++) begin : g_cell
        jds_cell #(
            .SHIFT (jds_pkg::QUO_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_stage (chain[k]),
            .o_stage (chain[k+1])
        );
    end

    jds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_stage (chain[jds_pkg::QUO_W]),
        .o_valid (o_valid),
        .o_req   (o_result)
    );

    // ---------------- assertions ----------------
    a_x_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.x_percent <= 8'sd100 && o_result.x_percent >= -8'sd100))
        else $error("x_percent out of range");

    a_y_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.y_percent <= 8'sd100 && o_result.y_percent >= -8'sd100))
        else $error("y_percent out of range");

    a_neutral : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_result.direction == jds_pkg::DIR_NEUTRAL) ==
                     (o_result.x_percent == 8'sd0 && o_result.y_percent == 8'sd0)))
        else $error("neutral direction mismatch");

    a_no_false_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while output slot free");

endmodule
